// ----- rtl/satp_pkg.sv -----
// satp_pkg: shared types and constants for the steering angle cordic pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package satp_pkg;

   // fixed point formats
   localparam int XY_SHIFT   = 24;   // fraction bits of cordic x and y
   localparam int Z_FRAC     = 24;   // fraction bits of the degree accumulator
   localparam int Z_BITS     = 33;   // signed degree accumulator width
   localparam int TABLE_LEN  = 24;
   localparam int ANGLE_BITS = 16;   // width of the result field

   // 90 degrees in the accumulator format
   localparam logic signed [Z_BITS-1:0] Z_MAX = 33'sd1509949440;

   // atan(2^-i) in degrees, Q24, rounded to nearest
   localparam logic [31:0] ATAN_DEG_Q24 [TABLE_LEN] = '{
      32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
      32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
      32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
      32'd234684,    32'd117342,    32'd58671,     32'd29335,
      32'd14668,     32'd7334,      32'd3667,      32'd1833,
      32'd917,       32'd458,       32'd229,       32'd115
   };

   // per item side information carried along the chain
   typedef struct packed {
      logic zero_dx;   // equal columns: answer is zero
      logic zero_dy;   // equal rows: answer is full scale
      logic neg;       // sign applied at the end
   } satp_flags_type;

endpackage

`default_nettype wire

// ----- rtl/satp_if.sv -----
// satp_req_if / satp_rsp_if: valid-ready channels for point pairs and angles
// depends on satp_pkg for the result width
`default_nettype none

interface satp_req_if #(
   parameter int COORD_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] car_x;
   logic [COORD_BITS-1:0] car_y;
   logic [COORD_BITS-1:0] dst_x;
   logic [COORD_BITS-1:0] dst_y;

   modport source (output valid, output car_x, output car_y, output dst_x,
                   output dst_y, input ready);
   modport sink   (input valid, input car_x, input car_y, input dst_x,
                   input dst_y, output ready);
endinterface

interface satp_rsp_if
   import satp_pkg::*;
();
   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS-1:0] angle_deg;

   modport source (output valid, output angle_deg, input ready);
   modport sink   (input valid, input angle_deg, output ready);
endinterface

`default_nettype wire

// ----- rtl/satp_prep.sv -----
// satp_prep: first cell, forms dx/dy magnitudes, sign and special-case flags
// depends on satp_pkg
`default_nettype none

module satp_prep
   import satp_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int XW         = COORD_BITS + XY_SHIFT + 3
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    up_valid,
   output      logic                    up_ready,
   input  wire logic [COORD_BITS-1:0]   car_x,
   input  wire logic [COORD_BITS-1:0]   car_y,
   input  wire logic [COORD_BITS-1:0]   dst_x,
   input  wire logic [COORD_BITS-1:0]   dst_y,
   output      logic                    dn_valid,
   input  wire logic                    dn_ready,
   output      logic signed [XW-1:0]    dn_x,
   output      logic signed [XW-1:0]    dn_y,
   output      logic signed [Z_BITS-1:0] dn_z,
   output      satp_flags_type          dn_flags
);

   logic signed [COORD_BITS:0] dx, dy;
   logic        [COORD_BITS:0] ndx, ndy;
   logic [COORD_BITS-1:0]      adx, ady;
   logic                       valid_ff;
   logic signed [XW-1:0]       x_ff, x_in, y_ff, y_in;
   satp_flags_type             flags_ff, flags_in;

   always_comb begin
      dx  = $signed({1'b0, dst_x}) - $signed({1'b0, car_x});
      dy  = $signed({1'b0, car_y}) - $signed({1'b0, dst_y});
      ndx = -dx;
      ndy = -dy;
      adx = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
      ady = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
      // vectoring starts from x = |dy|, y = |dx|
      x_in = $signed({{(XW-COORD_BITS-XY_SHIFT){1'b0}}, ady, {XY_SHIFT{1'b0}}});
      y_in = $signed({{(XW-COORD_BITS-XY_SHIFT){1'b0}}, adx, {XY_SHIFT{1'b0}}});
      flags_in.zero_dx = (dx == '0);
      flags_in.zero_dy = (dy == '0);
      if (dx == '0) begin
         flags_in.neg = 1'b0;
      end else if (dy == '0) begin
         flags_in.neg = dx[COORD_BITS];
      end else begin
         flags_in.neg = (dx[COORD_BITS] == dy[COORD_BITS]);
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         flags_ff <= flags_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_z     = '0;
   assign dn_flags = flags_ff;

endmodule

`default_nettype wire

// ----- rtl/satp_cell.sv -----
// satp_cell: one cordic vectoring rotation with its own pipeline register
// depends on satp_pkg for the arctangent table and flag type
`default_nettype none

module satp_cell
   import satp_pkg::*;
#(
   parameter int XW    = 39,
   parameter int STAGE = 0
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     up_valid,
   output      logic                     up_ready,
   input  wire logic signed [XW-1:0]     up_x,
   input  wire logic signed [XW-1:0]     up_y,
   input  wire logic signed [Z_BITS-1:0] up_z,
   input  wire satp_flags_type           up_flags,
   output      logic                     dn_valid,
   input  wire logic                     dn_ready,
   output      logic signed [XW-1:0]     dn_x,
   output      logic signed [XW-1:0]     dn_y,
   output      logic signed [Z_BITS-1:0] dn_z,
   output      satp_flags_type           dn_flags
);

   localparam logic signed [Z_BITS-1:0] STEP = $signed({1'b0, ATAN_DEG_Q24[STAGE]});

   logic                     valid_ff;
   logic signed [XW-1:0]     xs, ys, x_ff, x_in, y_ff, y_in;
   logic signed [Z_BITS-1:0] z_ff, z_in;
   satp_flags_type           flags_ff;

   always_comb begin
      xs = up_x >>> STAGE;
      ys = up_y >>> STAGE;
      if (!up_y[XW-1]) begin
         x_in = up_x + ys;
         y_in = up_y - xs;
         z_in = up_z + STEP;
      end else begin
         x_in = up_x - ys;
         y_in = up_y + xs;
         z_in = up_z - STEP;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         flags_ff <= up_flags;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_z     = z_ff;
   assign dn_flags = flags_ff;

endmodule

`default_nettype wire

// ----- rtl/satp_final.sv -----
// satp_final: clamps and rounds the accumulated angle, applies the sign
// depends on satp_pkg; its register is the block's output register
`default_nettype none

module satp_final
   import satp_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         up_valid,
   output      logic                         up_ready,
   input  wire logic signed [Z_BITS-1:0]     up_z,
   input  wire satp_flags_type               up_flags,
   output      logic                         dn_valid,
   input  wire logic                         dn_ready,
   output      logic signed [ANGLE_BITS-1:0] dn_angle
);

   localparam int SH      = Z_FRAC - ANGLE_FRAC_BITS;
   localparam int LIM_RAW = 90 << ANGLE_FRAC_BITS;
   localparam int MAG_LIM = (LIM_RAW > 32767) ? 32767 : LIM_RAW;
   localparam logic [Z_BITS-1:0]     HALF  = Z_BITS'(1) << (SH - 1);
   localparam logic [Z_BITS-1:0]     LIM_W = Z_BITS'(MAG_LIM);
   localparam logic [ANGLE_BITS-1:0] LIM_O = ANGLE_BITS'(MAG_LIM);

   logic signed [Z_BITS-1:0]     z_sel;
   logic        [Z_BITS-1:0]     z_r, m_full;
   logic        [ANGLE_BITS-1:0] mag;
   logic                         valid_ff;
   logic signed [ANGLE_BITS-1:0] angle_ff, angle_in;

   always_comb begin
      if (up_z[Z_BITS-1]) begin
         z_sel = '0;
      end else if (up_z > Z_MAX) begin
         z_sel = Z_MAX;
      end else begin
         z_sel = up_z;
      end
      z_r    = $unsigned(z_sel) + HALF;
      m_full = z_r >> SH;
      if (up_flags.zero_dx) begin
         mag = '0;
      end else if (up_flags.zero_dy || (m_full > LIM_W)) begin
         mag = LIM_O;
      end else begin
         mag = m_full[ANGLE_BITS-1:0];
      end
      angle_in = up_flags.neg ? -$signed(mag) : $signed(mag);
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         angle_ff <= angle_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_angle = angle_ff;

endmodule

`default_nettype wire

// ----- rtl/steering_angle_from_two_points_core.sv -----
// steering_angle_from_two_points_core: point pair in, steering angle out
// cells: one prep cell, one cell per rotation, one output cell; the chain is fully pipelined
// throughput one item per cycle unless rsp_ch stalls, since each rotation has its own cell
// every cell stalls only when it is full and its receiver is not ready, so bubbles collapse
// reset (synchronous, active high) empties every cell; data registers are not cleared
// depends on satp_pkg, satp_if, satp_prep, satp_cell, satp_final
`default_nettype none

module steering_angle_from_two_points_core
   import satp_pkg::*;
#(
   parameter int COORD_BITS      = 12,
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int CORDIC_STAGES   = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   satp_req_if.sink    req_ch,
   satp_rsp_if.source  rsp_ch
);

   // cordic x/y width: coordinate, fraction, headroom for gain and sqrt(2)
   localparam int XW      = COORD_BITS + XY_SHIFT + 3;
   localparam int N       = CORDIC_STAGES;
   localparam int LIM_RAW = 90 << ANGLE_FRAC_BITS;
   localparam int MAG_LIM = (LIM_RAW > 32767) ? 32767 : LIM_RAW;

   // chain taps: index 0 is the prep cell output, index N the last rotation
   logic                     valid_s [0:N];
   logic                     ready_s [0:N];
   logic signed [XW-1:0]     x_s     [0:N];
   logic signed [XW-1:0]     y_s     [0:N];
   logic signed [Z_BITS-1:0] z_s     [0:N];
   satp_flags_type           flags_s [0:N];

   // magnitudes, sign and special cases of the incoming item
   satp_prep #(
      .COORD_BITS (COORD_BITS),
      .XW         (XW)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_ch.valid),
      .up_ready (req_ch.ready),
      .car_x    (req_ch.car_x),
      .car_y    (req_ch.car_y),
      .dst_x    (req_ch.dst_x),
      .dst_y    (req_ch.dst_y),
      .dn_valid (valid_s[0]),
      .dn_ready (ready_s[0]),
      .dn_x     (x_s[0]),
      .dn_y     (y_s[0]),
      .dn_z     (z_s[0]),
      .dn_flags (flags_s[0])
   );

   // one rotation per cell, shift amount fixed by position
   for (genvar i = 0; i < N; i++) begin : g_cell
      satp_cell #(
         .XW    (XW),
         .STAGE (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid_s[i]),
         .up_ready (ready_s[i]),
         .up_x     (x_s[i]),
         .up_y     (y_s[i]),
         .up_z     (z_s[i]),
         .up_flags (flags_s[i]),
         .dn_valid (valid_s[i+1]),
         .dn_ready (ready_s[i+1]),
         .dn_x     (x_s[i+1]),
         .dn_y     (y_s[i+1]),
         .dn_z     (z_s[i+1]),
         .dn_flags (flags_s[i+1])
      );
   end

   // clamp, round, saturate, sign; holds the item until it is taken
   satp_final #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_final (
      .clock    (clock),
      .reset    (reset),
      .up_valid (valid_s[N]),
      .up_ready (ready_s[N]),
      .up_z     (z_s[N]),
      .up_flags (flags_s[N]),
      .dn_valid (rsp_ch.valid),
      .dn_ready (rsp_ch.ready),
      .dn_angle (rsp_ch.angle_deg)
   );

   // output never leaves the saturation band
   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.angle_deg <= MAG_LIM && rsp_ch.angle_deg >= -MAG_LIM))
      else $error("angle outside saturation band");

   // an accepted item lands in the prep cell
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> valid_s[0])
      else $error("accepted item lost at chain entry");

   // a stalled prep cell keeps its item and data
   a_prep_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_s[0] && !ready_s[0]) |=>
         (valid_s[0] && $stable(x_s[0]) && $stable(y_s[0]) && $stable(flags_s[0])))
      else $error("stalled prep cell dropped its item");

   // a stalled last rotation cell keeps its accumulated angle
   a_last_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_s[N] && !ready_s[N]) |=> (valid_s[N] && $stable(z_s[N])))
      else $error("stalled last cell dropped its item");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// testbench for steering_angle_from_two_points_core: random and directed point pairs
// predicts each angle with its own cordic model and checks every result in order
// depends on satp_pkg, satp_if and the core rtl

module testbench
   import satp_pkg::*;
();

   localparam int COORD_BITS      = 12;
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int CORDIC_STAGES   = 16;

   // accumulator is degrees in q24, rounded to nearest output fraction at the end
   localparam int     ACC_FRAC   = 24;
   localparam int     ROUND_SH   = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam longint ACC_LIMIT  = longint'(90) <<< ACC_FRAC;
   // full scale saturates at 90 degrees and at the 16 bit field
   localparam longint RIGHT_ANGLE = longint'(90) <<< ANGLE_FRAC_BITS;
   localparam longint FULL_SCALE  = (RIGHT_ANGLE > 32767) ? 32767 : RIGHT_ANGLE;

   // extra wait after every result is back, longer than the pipeline depth
   localparam int DRAIN_CYCLES = CORDIC_STAGES + 10;
   localparam int PHASE_ITEMS  = 225;
   localparam int PHASES       = 6;
   localparam int LONG_HOLD    = 120;

   // atan(2^-i) in degrees, q24, rounded to nearest
   localparam longint ATAN_STEP_Q24 [24] = '{
      754974720, 445687602, 235489088, 119537938,
      60000934,  30029717,  15018523,  7509720,
      3754917,   1877466,   938734,    469367,
      234684,    117342,    58671,     29335,
      14668,     7334,      3667,      1833,
      917,       458,       229,       115
   };

   typedef logic [COORD_BITS-1:0] coord_type;

   // ---------------------------------------------------------------
   // angle scoreboard: predicted angles waiting for the block's answers
   // ---------------------------------------------------------------
   class angle_scoreboard;
      logic signed [ANGLE_BITS-1:0] expected_angles[$];
      int mismatches = 0;

      // steering angle in degrees, q8, for one car point and one target point
      function automatic logic signed [ANGLE_BITS-1:0] steer_angle_q8(
         coord_type cx, coord_type cy, coord_type tx, coord_type ty);
         longint dx, dy, x, y, z, xs, ys, mag;
         bit neg;
         logic signed [ANGLE_BITS-1:0] angle;
         dx = longint'(tx) - longint'(cx);
         dy = longint'(cy) - longint'(ty);
         if (dx == 0) begin
            // equal columns: straight ahead whatever the rows
            mag = 0;
            neg = 0;
         end else if (dy == 0) begin
            // equal rows: full scale, negative when the target lies left
            mag = FULL_SCALE;
            neg = (dx < 0);
         end else begin
            // vectoring on (|dy|, |dx|)
            x = ((dy < 0) ? -dy : dy) <<< 24;
            y = ((dx < 0) ? -dx : dx) <<< 24;
            z = 0;
            for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
               xs = x >>> i;
               ys = y >>> i;
               if (y >= 0) begin
                  x = x + ys;
                  y = y - xs;
                  z = z + ATAN_STEP_Q24[i];
               end else begin
                  x = x - ys;
                  y = y + xs;
                  z = z - ATAN_STEP_Q24[i];
               end
            end
            if (z < 0) z = 0;
            if (z > ACC_LIMIT) z = ACC_LIMIT;
            mag = (z + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
            if (mag > FULL_SCALE) mag = FULL_SCALE;
            neg = ((dx < 0) == (dy < 0));
         end
         angle = mag[ANGLE_BITS-1:0];
         if (neg) angle = -angle;
         return angle;
      endfunction

      function void note_points(coord_type cx, coord_type cy, coord_type tx, coord_type ty);
         expected_angles.push_back(steer_angle_q8(cx, cy, tx, ty));
      endfunction

      function void check_angle(logic signed [ANGLE_BITS-1:0] got);
         logic signed [ANGLE_BITS-1:0] want;
         if (expected_angles.size() == 0) begin
            $error("angle_deg: no item pending, actual %0d", got);
            mismatches++;
         end else begin
            want = expected_angles.pop_front();
            if (got !== want) begin
               $error("angle_deg: expected %0d, actual %0d", want, got);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_angles.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   satp_req_if #(.COORD_BITS(COORD_BITS)) req_ch();
   satp_rsp_if rsp_ch();

   steering_angle_from_two_points_core #(
      .COORD_BITS      (COORD_BITS),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_STAGES   (CORDIC_STAGES)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   angle_scoreboard angles = new();

   // shared between sender and receiver
   bit steady_flow   = 1'b0;   // no idling on either side
   bit long_hold_req = 1'b0;   // receiver should hold off for a long stretch

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly no gap, some short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------
   // monitors: sample both handshakes at the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         angles.note_points(req_ch.car_x, req_ch.car_y, req_ch.dst_x, req_ch.dst_y);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         angles.check_angle(rsp_ch.angle_deg);
   end

   // ---------------------------------------------------------------
   // receiver: random stalls, plus one long hold on request
   // ---------------------------------------------------------------
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            // long stretch so the pipe fills and backs up into the input
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            hold_left = idle_len();
            if (hold_left == 0) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               rsp_ch.ready <= 1'b0;
               hold_left--;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // sender tasks, all called at a falling edge
   // ---------------------------------------------------------------

   // hold one item on the channel until it is taken, return at the next falling edge
   task automatic offer_points(coord_type cx, coord_type cy, coord_type tx, coord_type ty);
      req_ch.valid <= 1'b1;
      req_ch.car_x <= cx;
      req_ch.car_y <= cy;
      req_ch.dst_x <= tx;
      req_ch.dst_y <= ty;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // stop offering until every predicted angle has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (angles.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   initial begin
      coord_type cx, cy, tx, ty;
      int kind;

      req_ch.valid = 1'b0;
      req_ch.car_x = '0;
      req_ch.car_y = '0;
      req_ch.dst_x = '0;
      req_ch.dst_y = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, back to back
      steady_flow = 1'b1;
      offer_points(12'd0, 12'd0, 12'd0, 12'd0);             // all zero: equal columns
      offer_points(12'd5, 12'd0, 12'd5, 12'd4095);          // equal columns, target below
      offer_points(12'd4095, 12'd4095, 12'd4095, 12'd0);    // equal columns, far ahead
      offer_points(12'd2000, 12'd100, 12'd0, 12'd100);      // equal rows, target left
      offer_points(12'd0, 12'd100, 12'd4095, 12'd100);      // equal rows, target right
      offer_points(12'd4095, 12'd4095, 12'd0, 12'd4095);    // equal rows, widest left
      offer_points(12'd0, 12'd0, 12'd4095, 12'd4095);       // dx max, dy min
      offer_points(12'd4095, 12'd4095, 12'd0, 12'd0);       // dx min, dy max
      offer_points(12'd0, 12'd4095, 12'd4095, 12'd0);       // up right, 45 degrees
      offer_points(12'd4095, 12'd0, 12'd0, 12'd4095);       // down left, 45 degrees
      offer_points(12'd0, 12'd4095, 12'd1, 12'd0);          // tiny angle right
      offer_points(12'd1, 12'd4095, 12'd0, 12'd0);          // tiny angle left
      offer_points(12'd0, 12'd0, 12'd4095, 12'd1);          // nearly full scale
      offer_points(12'd4095, 12'd1, 12'd0, 12'd0);          // nearly full scale, other side
      offer_points(12'd100, 12'd200, 12'd150, 12'd120);     // target up right
      offer_points(12'd100, 12'd200, 12'd50, 12'd120);      // target up left
      offer_points(12'd100, 12'd200, 12'd150, 12'd280);     // target down right
      offer_points(12'd100, 12'd200, 12'd50, 12'd280);      // target down left
      offer_points(12'd2048, 12'd2048, 12'd2049, 12'd2047); // unit step diagonal
      offer_points(12'hAAA, 12'h555, 12'h555, 12'hAAA);     // alternating bit patterns
      wait_drained();

      // random part in phases, the sender drains after each one
      for (int phase = 0; phase < PHASES; phase++) begin
         steady_flow = (phase == 1 || phase == 3);
         // sender keeps offering while the receiver holds off for a long stretch
         if (phase == 3) long_hold_req = 1'b1;
         repeat (PHASE_ITEMS) begin
            pause_sender(idle_len());
            cx = coord_type'($urandom_range(0, 4095));
            cy = coord_type'($urandom_range(0, 4095));
            tx = coord_type'($urandom_range(0, 4095));
            ty = coord_type'($urandom_range(0, 4095));
            kind = $urandom_range(0, 9);
            case (kind)
               0: tx = cx;                                     // equal columns
               1: ty = cy;                                     // equal rows
               2: begin                                        // target close to the car
                  tx = cx + coord_type'($urandom_range(0, 16)) - coord_type'(8);
                  ty = cy + coord_type'($urandom_range(0, 16)) - coord_type'(8);
               end
               3: ty = $urandom_range(0, 1) ? cy + coord_type'(1)
                                            : cy - coord_type'(1);  // nearly sideways
               4: tx = $urandom_range(0, 1) ? cx + coord_type'(1)
                                            : cx - coord_type'(1);  // nearly straight
               default: ;
            endcase
            offer_points(cx, cy, tx, ty);
         end
         wait_drained();
      end

      if (angles.mismatches == 0 && angles.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // generous limit, far above the slowest legal run
   initial begin
      #12_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
